// ===== design/bcpd_pkg.sv =====
package bcpd_pkg;

  localparam int unsigned TimeBits  = 32;
  localparam int unsigned CfgAddrW  = 4;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned MsW       = 16;

  typedef logic [TimeBits-1:0] time_t;
  typedef logic [MsW-1:0]      ms_t;

  localparam logic [CfgIdxW-1:0] RegDebounce  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegClick     = 2'd1;
  localparam logic [CfgIdxW-1:0] RegLongPress = 2'd2;

  localparam ms_t DebounceReset  = 16'd50;
  localparam ms_t ClickReset     = 16'd600;
  localparam ms_t LongPressReset = 16'd1000;

  typedef struct packed {
    ms_t debounce_ms;
    ms_t click_ms;
    ms_t long_press_ms;
  } cfg_t;

endpackage

// ===== design/bcpd_if.sv =====
interface bcpd_in_if;
  logic        valid;
  logic        ready;
  logic        pin_level;
  logic [31:0] now_ms;

  modport source (output valid, output pin_level, output now_ms, input ready);
  modport sink (input valid, input pin_level, input now_ms, output ready);
endinterface

interface bcpd_out_if;
  logic valid;
  logic ready;
  logic single_click;
  logic double_click;
  logic hold_start;
  logic hold_during;
  logic hold_stop;

  modport source (
    output valid, output single_click, output double_click, output hold_start,
    output hold_during, output hold_stop, input ready
  );
  modport sink (
    input valid, input single_click, input double_click, input hold_start,
    input hold_during, input hold_stop, output ready
  );
endinterface

// ===== design/button_click_pattern_detector_top.sv =====
// channel | dir | handshake            | payload
// in_if   | in  | valid/ready          | pin_level, now_ms
// out_if  | out | valid/ready          | single_click, double_click, hold_start,
//         |     |                      | hold_during, hold_stop
// apb     | in  | psel/penable, pready | paddr, pwdata, prdata
//
// one transaction per cycle sustained while out_if.ready stays high; each sample passes
// through the input register and then the result register around the phase logic
// reset clears the phase, the press time and all valid flags; registers
// return to 50, 600 and 1000 ms
// a stalled result holds the input register, which then lowers in_if.ready
module button_click_pattern_detector_top
  import bcpd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  bcpd_in_if.sink             in_if,
  bcpd_out_if.source          out_if,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  cfg_t cfg;

  bcpd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bcpd_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_if  (in_if),
    .out_if (out_if)
  );

endmodule

// ===== design/bcpd_cfg.sv =====
module bcpd_cfg
  import bcpd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t               cfg_q;
  logic [CfgIdxW-1:0] idx;
  logic               wr_en;

  assign idx    = paddr[CfgAddrW-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms   <= DebounceReset;
      cfg_q.click_ms      <= ClickReset;
      cfg_q.long_press_ms <= LongPressReset;
    end else if (wr_en) begin
      unique case (idx)
        RegDebounce:  cfg_q.debounce_ms   <= pwdata[MsW-1:0];
        RegClick:     cfg_q.click_ms      <= pwdata[MsW-1:0];
        RegLongPress: cfg_q.long_press_ms <= pwdata[MsW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegDebounce:  prdata = CfgDataW'(cfg_q.debounce_ms);
      RegClick:     prdata = CfgDataW'(cfg_q.click_ms);
      RegLongPress: prdata = CfgDataW'(cfg_q.long_press_ms);
      default:      prdata = '0;
    endcase
  end

endmodule

// ===== design/bcpd_core.sv =====
module bcpd_core
  import bcpd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  bcpd_in_if.sink     in_if,
  bcpd_out_if.source  out_if
);

  typedef enum logic [2:0] {
    PhIdle   = 3'd0,
    PhFirst  = 3'd1,
    PhWait   = 3'd2,
    PhSecond = 3'd3,
    PhLong   = 3'd6
  } phase_e;

  // input register
  logic  s1_valid_q;
  logic  s1_level_q;
  time_t s1_now_q;

  phase_e phase_q, phase_d;
  time_t  press_time_q, press_time_d;

  logic  out_valid_q;
  logic  single_q, double_q, start_q, during_q, stop_q;
  logic  single_d, double_d, start_d, during_d, stop_d;

  logic  advance;
  logic  in_take;
  time_t elapsed;

  assign advance = s1_valid_q && (!out_valid_q || out_if.ready);
  assign in_if.ready = !s1_valid_q || advance;
  assign in_take = in_if.valid && in_if.ready;
  assign elapsed = s1_now_q - press_time_q;

  always_comb begin
    phase_d      = phase_q;
    press_time_d = press_time_q;
    single_d     = 1'b0;
    double_d     = 1'b0;
    start_d      = 1'b0;
    during_d     = 1'b0;
    stop_d       = 1'b0;
    unique case (phase_q)
      PhFirst: begin
        if (s1_level_q && (elapsed < TimeBits'(cfg_i.debounce_ms))) begin
          phase_d = PhIdle;
        end else if (s1_level_q) begin
          phase_d = PhWait;
        end else if (elapsed > TimeBits'(cfg_i.long_press_ms)) begin
          start_d  = 1'b1;
          during_d = 1'b1;
          phase_d  = PhLong;
        end
      end
      PhWait: begin
        if (elapsed > TimeBits'(cfg_i.click_ms)) begin
          single_d = 1'b1;
          phase_d  = PhIdle;
        end else if (!s1_level_q) begin
          phase_d = PhSecond;
        end
      end
      PhSecond: begin
        if (s1_level_q) begin
          double_d = 1'b1;
          phase_d  = PhIdle;
        end
      end
      PhLong: begin
        if (s1_level_q) begin
          stop_d  = 1'b1;
          phase_d = PhIdle;
        end else begin
          during_d = 1'b1;
        end
      end
      default: begin
        // unused codes behave as idle
        if (!s1_level_q) begin
          phase_d      = PhFirst;
          press_time_d = s1_now_q;
        end else begin
          phase_d = PhIdle;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      phase_q      <= PhIdle;
      press_time_q <= '0;
      single_q     <= 1'b0;
      double_q     <= 1'b0;
      start_q      <= 1'b0;
      during_q     <= 1'b0;
      stop_q       <= 1'b0;
    end else begin
      if (in_if.ready) begin
        s1_valid_q <= in_if.valid;
      end
      if (advance) begin
        out_valid_q  <= 1'b1;
        phase_q      <= phase_d;
        press_time_q <= press_time_d;
        single_q     <= single_d;
        double_q     <= double_d;
        start_q      <= start_d;
        during_q     <= during_d;
        stop_q       <= stop_d;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_level_q <= in_if.pin_level;
      s1_now_q   <= TimeBits'(in_if.now_ms);
    end
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.single_click = single_q;
  assign out_if.double_click = double_q;
  assign out_if.hold_start   = start_q;
  assign out_if.hold_during  = during_q;
  assign out_if.hold_stop    = stop_q;

endmodule

// ===== design/bcpd_checker.sv =====
module bcpd_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic single_i,
  input logic double_i,
  input logic start_i,
  input logic during_i,
  input logic stop_i,
  input logic pready_i
);

  // a long press start is always reported as held
  a_start_during : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && start_i |-> during_i)
    else $error("hold_start without hold_during");

  // one pattern event per result at most
  a_one_event : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> $countones({single_i, double_i, start_i, stop_i}) <= 1)
    else $error("more than one event in a result");

  // input only stalls behind a waiting result
  a_in_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without a pending result");

  // stalled result holds its flags
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i &&
      $stable({single_i, double_i, start_i, during_i, stop_i}))
    else $error("stalled result changed");

  // ready for a transaction on the first cycle after reset
  a_ready_after_reset : assert property (@(posedge clk_i)
    $rose(rst_ni) |-> in_ready_i && pready_i)
    else $error("not ready after reset");

endmodule

bind button_click_pattern_detector_top bcpd_checker u_bcpd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .single_i    (out_if.single_click),
  .double_i    (out_if.double_click),
  .start_i     (out_if.hold_start),
  .during_i    (out_if.hold_during),
  .stop_i      (out_if.hold_stop),
  .pready_i    (pready)
);

// ===== sim/button_click_pattern_detector_top_tb.sv =====
module button_click_pattern_detector_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bcpd_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;

  typedef enum logic [2:0] {
    PhIdle   = 3'd0,
    PhFirst  = 3'd1,
    PhWait   = 3'd2,
    PhSecond = 3'd3,
    PhLong   = 3'd6
  } phase_e;

  typedef struct packed {
    logic single_click;
    logic double_click;
    logic hold_start;
    logic hold_during;
    logic hold_stop;
  } events_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  bcpd_in_if  in_if ();
  bcpd_out_if out_if ();

  button_click_pattern_detector_top u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_if),
    .out_if  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5ns clk_i = ~clk_i;

  // button model state
  cfg_t    cfg_model;
  phase_e  phase_model;
  time_t   first_press_time;
  events_t pending_events[$];

  time_t       clock_ms;
  int unsigned mismatches = 0;
  int unsigned samples_sent = 0;
  int unsigned results_seen = 0;
  int unsigned singles_seen = 0;
  int unsigned doubles_seen = 0;
  int unsigned holds_seen = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_off_cycles = 0;
  bit          src_idle_on;
  bit          sink_idle_on;

  string field_names [5] = '{"hold_stop", "hold_during", "hold_start", "double_click",
                             "single_click"};

  function automatic events_t predict_events(input logic released, input time_t now);
    events_t ev;
    time_t   elapsed;
    ev      = '0;
    elapsed = now - first_press_time;
    case (phase_model)
      PhFirst: begin
        if (released && elapsed < cfg_model.debounce_ms) begin
          phase_model = PhIdle;
        end else if (released) begin
          phase_model = PhWait;
        end else if (elapsed > cfg_model.long_press_ms) begin
          ev.hold_start  = 1'b1;
          ev.hold_during = 1'b1;
          phase_model    = PhLong;
        end
      end
      PhWait: begin
        if (elapsed > cfg_model.click_ms) begin
          ev.single_click = 1'b1;
          phase_model     = PhIdle;
        end else if (!released) begin
          phase_model = PhSecond;
        end
      end
      PhSecond: begin
        if (released) begin
          ev.double_click = 1'b1;
          phase_model     = PhIdle;
        end
      end
      PhLong: begin
        if (released) begin
          ev.hold_stop = 1'b1;
          phase_model  = PhIdle;
        end else begin
          ev.hold_during = 1'b1;
        end
      end
      default: begin
        if (!released) begin
          phase_model      = PhFirst;
          first_press_time = now;
        end else begin
          phase_model = PhIdle;
        end
      end
    endcase
    return ev;
  endfunction

  function automatic void note_mismatch(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch in %s: expected %0h, got %0h", what, want, got);
    end
  endfunction

  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) begin
      return 0;
    end
    if (roll < 95) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // offset from a press that lands on, under or over a threshold
  function automatic time_t near_limit(input ms_t limit);
    case ($urandom_range(0, 4))
      0: return time_t'(limit) + time_t'($urandom_range(0, 2)) - 1;
      1: return time_t'($urandom_range(0, limit));
      2: return time_t'(limit) + time_t'($urandom_range(2, 300));
      3: return time_t'($urandom_range(0, 8));
      default: return time_t'($urandom_range(0, 2 * limit + 10));
    endcase
  endfunction

  task automatic send_sample(input logic released, input time_t now);
    int unsigned gap;
    in_if.valid     <= 1'b1;
    in_if.pin_level <= released;
    in_if.now_ms    <= now;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    pending_events.push_back(predict_events(released, now));
    samples_sent++;
    gap = src_idle_on ? idle_len() : 0;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_setting(input logic [CfgIdxW-1:0] idx, input ms_t value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CfgAddrW'({idx, 2'b00});
    pwdata  <= {16'($urandom()), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      RegDebounce:  cfg_model.debounce_ms   = value;
      RegClick:     cfg_model.click_ms      = value;
      RegLongPress: cfg_model.long_press_ms = value;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic check_setting(input logic [CfgIdxW-1:0] idx, input ms_t want);
    ms_t got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= CfgAddrW'({idx, 2'b00});
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    got     = prdata[MsW-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== want) begin
      note_mismatch($sformatf("read of register %0d", idx), 32'(want), 32'(got));
    end
    @(posedge clk_i);
  endtask

  task automatic check_all_settings();
    check_setting(RegDebounce, cfg_model.debounce_ms);
    check_setting(RegClick, cfg_model.click_ms);
    check_setting(RegLongPress, cfg_model.long_press_ms);
  endtask

  task automatic apply_settings(input ms_t debounce, input ms_t click, input ms_t long_press);
    wait_idle();
    write_setting(RegDebounce, debounce);
    write_setting(RegClick, click);
    write_setting(RegLongPress, long_press);
    check_all_settings();
  endtask

  task automatic send_pattern();
    time_t press_at;
    time_t t;
    press_at = clock_ms;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        send_sample(1'b0, press_at);
        send_sample(1'b1, press_at + near_limit(cfg_model.debounce_ms));
        repeat ($urandom_range(1, 2)) begin
          send_sample(1'b1, press_at + near_limit(cfg_model.click_ms));
        end
      end
      3, 4, 5: begin
        send_sample(1'b0, press_at);
        send_sample(1'b1, press_at + near_limit(cfg_model.debounce_ms));
        t = press_at + near_limit(cfg_model.click_ms);
        send_sample(1'b0, t);
        send_sample(1'b1, t + time_t'($urandom_range(0, 400)));
      end
      6, 7: begin
        send_sample(1'b0, press_at);
        repeat ($urandom_range(1, 5)) begin
          send_sample(1'b0, press_at + near_limit(cfg_model.long_press_ms));
        end
        send_sample(1'b1, press_at + cfg_model.long_press_ms + time_t'($urandom_range(1, 500)));
      end
      8: begin
        // broken sequence around one press
        repeat ($urandom_range(1, 4)) begin
          send_sample(1'($urandom()), press_at + near_limit(cfg_model.click_ms));
        end
      end
      default: begin
        repeat ($urandom_range(1, 3)) send_sample(1'($urandom()), time_t'($urandom()));
      end
    endcase
    case ($urandom_range(0, 19))
      0:       clock_ms = time_t'($urandom());
      1:       clock_ms = 32'hFFFF_FFFF - time_t'($urandom_range(0, 70000));
      default: clock_ms = clock_ms + time_t'($urandom_range(1, 140000));
    endcase
  endtask

  task automatic run_patterns(input int unsigned count);
    int unsigned stop_at;
    stop_at = samples_sent + count;
    while (samples_sent < stop_at) send_pattern();
  endtask

  task automatic test_reset_values();
    check_all_settings();
  endtask

  task automatic test_single_click();
    send_sample(1'b1, 32'd0);
    send_sample(1'b0, 32'd1000);
    send_sample(1'b1, 32'd1050);
    send_sample(1'b1, 32'd1600);
    send_sample(1'b1, 32'd1601);
  endtask

  task automatic test_bounce();
    send_sample(1'b0, 32'd2000);
    send_sample(1'b1, 32'd2049);
  endtask

  task automatic test_double_click();
    send_sample(1'b0, 32'd3000);
    send_sample(1'b1, 32'd3100);
    send_sample(1'b0, 32'd3600);
    send_sample(1'b0, 32'd3700);
    send_sample(1'b1, 32'd3800);
  endtask

  task automatic test_long_press();
    send_sample(1'b0, 32'd5000);
    send_sample(1'b0, 32'd6000);
    send_sample(1'b0, 32'd6001);
    send_sample(1'b0, 32'd9000);
    send_sample(1'b1, 32'd9001);
  endtask

  task automatic test_time_wrap();
    send_sample(1'b0, 32'hFFFF_FFF0);
    send_sample(1'b1, 32'h0000_0030);
    send_sample(1'b1, 32'h0000_0249);
    send_sample(1'b0, 32'hFFFF_FFFF);
    send_sample(1'b0, 32'h0000_03E8);
    send_sample(1'b1, 32'h0000_03E9);
  endtask

  task automatic test_unused_register();
    wait_idle();
    write_setting(RegUnused, ms_t'($urandom()));
    check_all_settings();
  endtask

  task automatic test_backpressure();
    wait_idle();
    src_idle_on     = 1'b0;
    hold_off_cycles = 300;
    run_patterns(40);
    src_idle_on = 1'b1;
  endtask

  task automatic test_random_settings();
    wait_idle();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    run_patterns(250);
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    apply_settings(16'd0, 16'd0, 16'd0);
    run_patterns(250);
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_patterns(250);
    repeat (3) begin
      apply_settings(ms_t'($urandom_range(0, 200)), ms_t'($urandom_range(0, 1500)),
                     ms_t'($urandom_range(0, 3000)));
      run_patterns(175);
    end
    apply_settings(ms_t'($urandom()), ms_t'($urandom()), ms_t'($urandom()));
    run_patterns(175);
  endtask

  initial begin : main_sequence
    rst_ni          <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.pin_level <= 1'b1;
    in_if.now_ms    <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    cfg_model        = '{DebounceReset, ClickReset, LongPressReset};
    phase_model      = PhIdle;
    first_press_time = '0;
    clock_ms         = time_t'($urandom());
    src_idle_on      = 1'b1;
    sink_idle_on     = 1'b1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_single_click();
    test_bounce();
    test_double_click();
    test_long_press();
    test_time_wrap();
    test_unused_register();
    test_backpressure();
    test_random_settings();

    wait_idle();
    repeat (8) @(posedge clk_i);
    $display("%0d samples sent, %0d results checked: %0d single, %0d double, %0d long presses",
             samples_sent, results_seen, singles_seen, doubles_seen, holds_seen);
    $display("settings at reset, all zero, all maximum and random; one long result stall");
    if (mismatches == 0 && pending_events.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : result_sink
    int unsigned stall;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      stall = sink_idle_on ? idle_len() : 0;
      if (hold_off_cycles != 0) begin
        stall           = hold_off_cycles;
        hold_off_cycles = 0;
      end
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_results
    events_t got;
    events_t want;
    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got = {out_if.single_click, out_if.double_click, out_if.hold_start, out_if.hold_during,
             out_if.hold_stop};
      results_seen++;
      if (got.single_click) singles_seen++;
      if (got.double_click) doubles_seen++;
      if (got.hold_start) holds_seen++;
      if (pending_events.size() == 0) begin
        note_mismatch($sformatf("unexpected result %0d", results_seen), '0, 32'(got));
      end else begin
        want = pending_events.pop_front();
        for (int i = 4; i >= 0; i--) begin
          if (got[i] !== want[i]) begin
            note_mismatch($sformatf("%s of result %0d", field_names[i], results_seen),
                          32'(want[i]), 32'(got[i]));
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("run stopped by watchdog after %0d cycles", cycle_count);
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule
